// ----- hw/rtl/cba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg: shared types and constants of the contiguous block allocator
// Holds the request and result layouts, the command codes, the controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cba_pkg;

	// Field widths of the request, the result and the configuration register.
	localparam int START_W = 10;
	localparam int COUNT_W = 11;
	localparam int TOTAL_W = 11;

	// The map is held as words of this many blocks.
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	localparam int MAX_BLOCKS_DEF = 1024;

	localparam logic [TOTAL_W-1:0] TOTAL_RST = 11'd1024;

	// Request operation codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [START_W-1:0] start_block;
		logic [COUNT_W-1:0] block_count;
	} req_t;

	typedef struct packed {
		logic               success;
		logic [START_W-1:0] run_start;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_MARK,
		ST_REPORT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_en;
		logic load;
		logic scan_go;
		logic free_load;
		logic mark_en;
		logic res_ok;
		logic res_fail;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic zero_count;
		logic no_fit;
		logic free_empty;
		logic hit;
		logic scan_end;
		logic mark_last;
	} ctl_sts_t;

endpackage

// ----- hw/rtl/cba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cba_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/cba_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_datapath: block map, word scanner and run marker
// Holds the used map in a RAM of 32-bit words, the total register, the
// two-stage first-fit scanner and the read-modify-write run marker.
// ----------------------------------------------------------------------------
module cba_datapath #(
	parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cba_pkg::TOTAL_W-1:0]   cfg_wdata,
	input  cba_pkg::req_t                 req,
	input  cba_pkg::ctl_cmd_t             cmd,
	output cba_pkg::ctl_sts_t             sts,
	output cba_pkg::rsp_t                 rsp
);

	localparam int WORD_W  = cba_pkg::WORD_W;
	localparam int BIT_W   = cba_pkg::BIT_W;
	localparam int COUNT_W = cba_pkg::COUNT_W;
	localparam int START_W = cba_pkg::START_W;
	localparam int NWORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int SUM_W   = COUNT_W + 1;
	localparam int ARITH_W = (WADDR_W + BIT_W + 1 > SUM_W) ? WADDR_W + BIT_W + 1 : SUM_W;
	localparam int WIDX_W  = ARITH_W - BIT_W;
	localparam int RUN_W   = BIT_W + 1;

	// Configuration and request registers.
	logic [cba_pkg::TOTAL_W-1:0] total_q;
	cba_pkg::req_t               req_q;
	logic [ARITH_W-1:0]          lim_q;
	logic [ARITH_W-1:0]          lim_d;
	logic [ARITH_W-1:0]          tot_ext;
	logic [ARITH_W-1:0]          cnt_ext;
	logic [ARITH_W-1:0]          start_ext;
	logic [ARITH_W-1:0]          end_sum;
	logic [ARITH_W-1:0]          end_clip;
	logic [ARITH_W-1:0]          lim_m1;
	logic [WIDX_W-1:0]           scan_lastw;
	logic [WIDX_W-1:0]           lim_w;
	logic [BIT_W-1:0]            lim_b;

	// Clearing sweep.
	logic [WADDR_W-1:0] clr_q;

	// Scanner.
	logic                scan_rd;
	logic [WIDX_W-1:0]   scan_idx_q;
	logic                scan_all_q;
	logic [COUNT_W-1:0]  need_q;
	logic                v_s1;
	logic [WIDX_W-1:0]   w_s1;
	logic                last_s1;
	logic [WORD_W-1:0]   vmask;
	logic [WORD_W-1:0]   used_eff;
	logic [RUN_W-1:0]    pfx [WORD_W];
	logic [RUN_W-1:0]    run_a [WORD_W];
	logic [WORD_W-1:0]   free_a;
	logic                v_s2;
	logic [WIDX_W-1:0]   w_s2;
	logic                last_s2;
	logic [RUN_W-1:0]    run_s2 [WORD_W];
	logic [WORD_W-1:0]   free_s2;
	logic [WORD_W-1:0]   hit_vec;
	logic [BIT_W-1:0]    jh;
	logic                found;
	logic                hit;
	logic [ARITH_W-1:0]  pos;
	logic [ARITH_W-1:0]  run_begin;

	// Marker.
	logic [ARITH_W-1:0] lo_q;
	logic [ARITH_W-1:0] last_q;
	logic [WIDX_W-1:0]  mk_idx_q;
	logic               mk_all_q;
	logic               mk_rd;
	logic               m_v_s1;
	logic [WIDX_W-1:0]  m_w_s1;
	logic [WIDX_W-1:0]  lo_w;
	logic [WIDX_W-1:0]  last_w;
	logic [WORD_W-1:0]  mask_lo;
	logic [WORD_W-1:0]  mask_hi;
	logic [WORD_W-1:0]  mk_wdata;

	// RAM ports.
	logic               ram_we;
	logic [WADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [WADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0]  ram_rdata;

	// Result.
	logic               ok_q;
	logic [START_W-1:0] first_q;

	// ---------------- request decode ----------------
	assign tot_ext   = ARITH_W'(total_q);
	assign lim_d     = (tot_ext > ARITH_W'(MAX_BLOCKS)) ? ARITH_W'(MAX_BLOCKS) : tot_ext;
	assign cnt_ext   = ARITH_W'(req_q.block_count);
	assign start_ext = ARITH_W'(req_q.start_block);
	assign end_sum   = start_ext + cnt_ext;
	assign end_clip  = (end_sum > lim_q) ? lim_q : end_sum;
	assign lim_m1    = lim_q - ARITH_W'(1);
	assign scan_lastw = lim_m1[ARITH_W-1:BIT_W];
	assign lim_w     = lim_q[ARITH_W-1:BIT_W];
	assign lim_b     = lim_q[BIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= cba_pkg::TOTAL_RST;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			lim_q <= lim_d;
		end
	end

	// ---------------- clearing sweep ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + WADDR_W'(1);
		end
	end

	// ---------------- scanner: word fetch ----------------
	assign scan_rd = cmd.scan_go & ~scan_all_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			scan_all_q <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_idx_q <= '0;
				scan_all_q <= 1'b0;
			end else if (scan_rd) begin
				if (scan_idx_q == scan_lastw) begin
					scan_all_q <= 1'b1;
				end else begin
					scan_idx_q <= scan_idx_q + WIDX_W'(1);
				end
			end
			v_s1 <= scan_rd;
			v_s2 <= v_s1 & cmd.scan_go;
		end
	end

	always_ff @(posedge clk) begin
		w_s1    <= scan_idx_q;
		last_s1 <= (scan_idx_q == scan_lastw);
	end

	// ---------------- scanner stage A: free run ending at each bit ----------------
	// Blocks at or above the limit read as used so that no run crosses it.
	always_comb begin
		if (w_s1 < lim_w) begin
			vmask = '1;
		end else begin
			vmask = ~({WORD_W{1'b1}} << lim_b);
		end
		used_eff = ram_rdata | ~vmask;
		for (int j = 0; j < WORD_W; j++) begin
			pfx[j] = used_eff[j] ? RUN_W'(j + 1) : '0;
		end
		// Log-depth prefix of the last used position (plus one) at or below each bit.
		for (int l = 0; l < BIT_W; l++) begin
			for (int j = WORD_W - 1; j >= 0; j--) begin
				if (j >= (1 << l) && pfx[j] == '0) begin
					pfx[j] = pfx[j - (1 << l)];
				end
			end
		end
		for (int j = 0; j < WORD_W; j++) begin
			run_a[j]  = RUN_W'(j + 1) - pfx[j];
			free_a[j] = (pfx[j] == '0);
		end
	end

	always_ff @(posedge clk) begin
		w_s2    <= w_s1;
		last_s2 <= last_s1;
		run_s2  <= run_a;
		free_s2 <= free_a;
	end

	// ---------------- scanner stage B: first fit ----------------
	// need_q is what the run carried in from earlier words still lacks.
	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			hit_vec[j] = free_s2[j] ? (COUNT_W'(run_s2[j]) >= need_q)
			                        : (COUNT_W'(run_s2[j]) >= req_q.block_count);
		end
		jh = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				jh = BIT_W'(j);
			end
		end
		found = |hit_vec;
	end

	assign hit       = v_s2 & cmd.scan_go & found;
	assign pos       = {w_s2, jh};
	assign run_begin = pos + ARITH_W'(1) - cnt_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= '0;
		end else if (cmd.load) begin
			need_q <= req.block_count;
		end else if (v_s2 && cmd.scan_go && !found) begin
			if (free_s2[WORD_W-1]) begin
				need_q <= need_q - COUNT_W'(WORD_W);
			end else begin
				need_q <= req_q.block_count - COUNT_W'(run_s2[WORD_W-1]);
			end
		end
	end

	// ---------------- run marker ----------------
	assign mk_rd  = cmd.mark_en & ~mk_all_q;
	assign lo_w   = lo_q[ARITH_W-1:BIT_W];
	assign last_w = last_q[ARITH_W-1:BIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mk_idx_q <= '0;
			mk_all_q <= 1'b1;
			m_v_s1   <= 1'b0;
		end else begin
			if (cmd.free_load) begin
				mk_idx_q <= start_ext[ARITH_W-1:BIT_W];
				mk_all_q <= 1'b0;
			end else if (hit) begin
				mk_idx_q <= run_begin[ARITH_W-1:BIT_W];
				mk_all_q <= 1'b0;
			end else if (mk_rd) begin
				if (mk_idx_q == last_w) begin
					mk_all_q <= 1'b1;
				end else begin
					mk_idx_q <= mk_idx_q + WIDX_W'(1);
				end
			end
			m_v_s1 <= mk_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.free_load) begin
			lo_q   <= start_ext;
			last_q <= end_clip - ARITH_W'(1);
		end else if (hit) begin
			lo_q   <= run_begin;
			last_q <= pos;
		end
		m_w_s1 <= mk_idx_q;
	end

	always_comb begin
		mask_lo = (m_w_s1 == lo_w) ? ({WORD_W{1'b1}} << lo_q[BIT_W-1:0]) : '1;
		mask_hi = (m_w_s1 == last_w) ? ({WORD_W{1'b1}} >> (~last_q[BIT_W-1:0])) : '1;
		if (req_q.cmd == cba_pkg::CMD_ALLOC) begin
			mk_wdata = ram_rdata | (mask_lo & mask_hi);
		end else begin
			mk_wdata = ram_rdata & ~(mask_lo & mask_hi);
		end
	end

	// ---------------- map RAM ----------------
	assign ram_we    = cmd.clr_en | m_v_s1;
	assign ram_waddr = cmd.clr_en ? clr_q : m_w_s1[WADDR_W-1:0];
	assign ram_wdata = cmd.clr_en ? '0 : mk_wdata;
	assign ram_re    = scan_rd | mk_rd;
	assign ram_raddr = scan_rd ? scan_idx_q[WADDR_W-1:0] : mk_idx_q[WADDR_W-1:0];

	cba_ram #(
		.WIDTH  (WORD_W),
		.DEPTH  (NWORDS),
		.ADDR_W (WADDR_W)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------- result ----------------
	always_ff @(posedge clk) begin
		if (cmd.res_ok) begin
			ok_q    <= 1'b1;
			first_q <= '0;
		end else if (cmd.res_fail) begin
			ok_q    <= 1'b0;
			first_q <= '0;
		end else if (hit) begin
			ok_q    <= 1'b1;
			first_q <= run_begin[START_W-1:0];
		end
	end

	assign rsp.success   = ok_q;
	assign rsp.run_start = first_q;

	// ---------------- status ----------------
	assign sts.clr_last   = (clr_q == WADDR_W'(NWORDS - 1));
	assign sts.is_free    = (req_q.cmd == cba_pkg::CMD_FREE);
	assign sts.zero_count = (req_q.block_count == '0);
	assign sts.no_fit     = (lim_q == '0) || (cnt_ext > lim_q);
	assign sts.free_empty = (end_clip <= start_ext);
	assign sts.hit        = hit;
	assign sts.scan_end   = v_s2 & cmd.scan_go & last_s2 & ~found;
	assign sts.mark_last  = m_v_s1 & (m_w_s1 == last_w);

	// ---------------- assertions ----------------
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_go |-> !ram_we)
		else $error("map written during a scan");

	a_need_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_go && v_s2) |-> (need_q != '0))
		else $error("scan carried a satisfied run past its word");

	a_hit_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (pos < lim_q))
		else $error("fit found at or above the block limit");

endmodule

// ----- hw/rtl/cba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ctrl: allocator sequencer
// Steps the datapath through clearing, request check, scan, marking and
// result report.
// ----------------------------------------------------------------------------
module cba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cba_pkg::ctl_sts_t   sts,
	output cba_pkg::ctl_cmd_t   cmd,
	output logic                busy,
	output logic                done
);

	cba_pkg::state_t state_q;
	cba_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cba_pkg::ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = cba_pkg::ST_IDLE;
				end
			end
			cba_pkg::ST_IDLE: begin
				if (start) begin
					state_d = cba_pkg::ST_CHECK;
				end
			end
			cba_pkg::ST_CHECK: begin
				if (sts.is_free) begin
					state_d = sts.free_empty ? cba_pkg::ST_REPORT : cba_pkg::ST_MARK;
				end else if (sts.zero_count || sts.no_fit) begin
					state_d = cba_pkg::ST_REPORT;
				end else begin
					state_d = cba_pkg::ST_SCAN;
				end
			end
			cba_pkg::ST_SCAN: begin
				if (sts.hit) begin
					state_d = cba_pkg::ST_MARK;
				end else if (sts.scan_end) begin
					state_d = cba_pkg::ST_REPORT;
				end
			end
			cba_pkg::ST_MARK: begin
				if (sts.mark_last) begin
					state_d = cba_pkg::ST_REPORT;
				end
			end
			cba_pkg::ST_REPORT: begin
				state_d = cba_pkg::ST_IDLE;
			end
			default: begin
				state_d = cba_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			cba_pkg::ST_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			cba_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			cba_pkg::ST_CHECK: begin
				if (sts.is_free) begin
					cmd.res_ok    = 1'b1;
					cmd.free_load = ~sts.free_empty;
				end else if (sts.zero_count) begin
					cmd.res_ok = 1'b1;
				end else if (sts.no_fit) begin
					cmd.res_fail = 1'b1;
				end
			end
			cba_pkg::ST_SCAN: begin
				cmd.scan_go  = 1'b1;
				cmd.res_fail = sts.scan_end;
			end
			cba_pkg::ST_MARK: begin
				cmd.mark_en = 1'b1;
			end
			cba_pkg::ST_REPORT: begin
				done = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

endmodule

// ----- hw/rtl/contiguous_block_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator_top: first-fit bitmap block allocator
// Keeps a used mark per block and serves allocate and free requests on runs
// of contiguous blocks.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low; busy then stays
// high until the single result has been shown. The result is on rsp for
// exactly one cycle with done high, and the receiver must take it then since
// it cannot hold the block off. After reset the block first clears its map
// of MAX_BLOCKS/32 words (rounded up), one word per cycle, busy high; writes
// to the total register are taken at any time but are meant to happen only
// while the block is idle. The map is a RAM of 32-bit words with one read and
// one write port, and that port pair sets the timing: an allocate is checked,
// then walks the words from block 0 one per cycle through a two-stage scanner
// up to the word k holding the end of the first fitting run, then
// read-modify-writes the n words the run covers and reports. A failing
// allocate walks all words below the limit (the total clipped to MAX_BLOCKS);
// a free read-modify-writes its words with no scan. A zero count allocate,
// an allocate larger than the limit, or a free starting at or beyond it is
// answered from the check alone. The next request can be given in the cycle
// after done. On a free, or a failed allocate, run_start is 0.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_top #(
	parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  cba_pkg::req_t               req,
	output logic                        busy,
	output logic                        done,
	output cba_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic [cba_pkg::TOTAL_W-1:0] cfg_wdata
);

	// Command and status bundles between the sequencer and the datapath.
	cba_pkg::ctl_cmd_t cmd;
	cba_pkg::ctl_sts_t sts;

	// The sequencer owns the handshake: busy and the result strobe come
	// straight from its state.
	cba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the map, the total register and the result
	// register, which stays stable from the end of the work until done.
	cba_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

	// Every accepted transfer leads to work, and the block is free again
	// right after its result.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after its result");

endmodule
